### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define SFH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### rtl/sfh_pkg.sv
// ----------------------------------------------------------------------------
// sfh_pkg
// Types, codes and tables shared by the sample framer modules.
// ----------------------------------------------------------------------------
package sfh_pkg;

	localparam logic [1:0] OPC_SAMPLE  = 2'd0;
	localparam logic [1:0] OPC_COMMAND = 2'd1;
	localparam logic [1:0] OPC_SEND    = 2'd2;

	localparam logic [7:0] CMD_TOGGLE    = 8'hF8;
	localparam logic [7:0] CMD_HANDSHAKE = 8'h80;
	localparam logic [7:0] CMD_START     = 8'h8F;

	localparam logic KIND_DATA      = 1'b0;
	localparam logic KIND_HANDSHAKE = 1'b1;

	localparam logic [3:0]  TYPE_BASE     = 4'h8;
	localparam logic [11:0] TICK_LIMIT    = 12'h7FF;
	localparam logic [11:0] TICK_STEP_IMP = 12'd30;
	localparam logic [11:0] TICK_STEP_SIG = 12'd10;
	localparam logic [2:0]  PHASE_LAST    = 3'd5;

	typedef enum logic [2:0] {
		K_SAMPLE,
		K_TOGGLE,
		K_HANDSHAKE,
		K_START,
		K_SEND
	} op_kind_t;

	typedef enum logic [1:0] {
		LP_WAIT,
		LP_RESP,
		LP_START,
		LP_STREAM
	} link_phase_t;

	typedef enum logic [1:0] {
		RH_NONE,
		RH_FIRST,
		RH_SECOND
	} ready_half_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_SEND
	} eng_state_t;

	typedef enum logic [1:0] {
		SRC_CONST,
		SRC_STORE,
		SRC_PENDING
	} word_src_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [15:0] sample;
		logic        accepted;
	} op_t;

	typedef struct packed {
		logic        result_kind;
		logic [15:0] frame_word;
		logic        is_last;
		logic        response_variant;
	} res_t;

	function automatic logic [7:0] phase_delay(input logic [2:0] phase);
		logic [7:0] d;
		case (phase)
			3'd0: d = 8'd0;
			3'd1: d = 8'd13;
			3'd2: d = 8'd25;
			3'd3: d = 8'd38;
			3'd4: d = 8'd50;
			3'd5: d = 8'd63;
			default: d = 8'd0;
		endcase
		return d;
	endfunction

endpackage

### rtl/sfh_fifo.sv
// ----------------------------------------------------------------------------
// sfh_fifo
// Small synchronous FIFO with fill count; DEPTH is a power of two.
// ----------------------------------------------------------------------------
module sfh_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign rd_data = mem_q[rptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + AW'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule

### rtl/sfh_front.sv
// ----------------------------------------------------------------------------
// sfh_front
// Classifies incoming requests and drops those that have no effect.
// ----------------------------------------------------------------------------
module sfh_front (
	input  logic         [1:0]  opcode,
	input  logic         [15:0] sample_value,
	input  logic         [7:0]  command_byte,
	input  logic                link_configured,
	input  logic                host_accepts,
	output logic                keep,
	output sfh_pkg::op_t        op
);
	import sfh_pkg::*;

	always_comb begin
		keep        = 1'b0;
		op.kind     = K_SAMPLE;
		op.sample   = sample_value;
		op.accepted = host_accepts;
		unique case (opcode)
			OPC_SAMPLE: begin
				keep = 1'b1;
			end
			OPC_COMMAND: begin
				unique case (command_byte)
					CMD_TOGGLE: begin
						keep    = 1'b1;
						op.kind = K_TOGGLE;
					end
					CMD_HANDSHAKE: begin
						keep    = 1'b1;
						op.kind = K_HANDSHAKE;
					end
					CMD_START: begin
						keep    = 1'b1;
						op.kind = K_START;
					end
					default: keep = 1'b0;
				endcase
			end
			OPC_SEND: begin
				keep    = link_configured;
				op.kind = K_SEND;
			end
			default: keep = 1'b0;
		endcase
	end

endmodule

### rtl/sfh_back.sv
// ----------------------------------------------------------------------------
// sfh_back
// Execution engine: sample history, ping-pong store, link handshake and
// frame emission with a one-stage read pipeline into the result queue.
// ----------------------------------------------------------------------------
module sfh_back #(
	parameter int FRAME_SAMPLES = 30,
	parameter int HISTORY_DEPTH = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_empty,
	input  sfh_pkg::op_t  op,
	output logic          op_pop,
	input  logic          out_room,
	output logic          res_push,
	output sfh_pkg::res_t res
);
	import sfh_pkg::*;

	localparam int PP_DEPTH = 2 * FRAME_SAMPLES;
	localparam int PP_W     = (PP_DEPTH > 1) ? $clog2(PP_DEPTH) : 1;
	localparam int PD_W     = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
	localparam int WP_W     = $clog2(PP_DEPTH + 1);
	localparam int HI_W     = $clog2(HISTORY_DEPTH);
	localparam int WI_W     = $clog2(FRAME_SAMPLES + 2);

	localparam logic [WI_W-1:0] WI_LAST  = WI_W'(FRAME_SAMPLES + 1);
	localparam logic [WI_W-1:0] WI_TICK  = WI_W'(1);
	localparam logic [WI_W-1:0] WI_HEAD  = WI_W'(0);
	localparam logic [WP_W-1:0] WP_HALF  = WP_W'(FRAME_SAMPLES);
	localparam logic [WP_W-1:0] WP_FULL  = WP_W'(PP_DEPTH);
	localparam logic [PP_W-1:0] PP_BASE2 = PP_W'(FRAME_SAMPLES);
	localparam logic [8:0]      HD9      = 9'(HISTORY_DEPTH);

	eng_state_t  state_q, state_d;
	link_phase_t lp_q, lp_d;
	ready_half_t ready_q;

	logic                     imp_q;
	logic [WP_W-1:0]          wp_q;
	logic [2:0]               dph_q;
	logic [7:0]               hp_q;
	logic [HISTORY_DEPTH-1:0] hvalid_q;
	logic                     pend_q;
	logic [7:0]               seq_q;
	logic [3:0]               type_q;
	logic [10:0]              tick_q;
	logic [WI_W-1:0]          widx_q;
	logic [PP_W-1:0]          base_q;
	logic                     src_pend_q;
	logic                     acc_q;
	logic [15:0]              sample_q;
	logic                     use_hist_q;
	logic                     hv_q;

	logic [15:0] hist_mem [HISTORY_DEPTH];
	logic [15:0] pp_mem [PP_DEPTH];
	logic [15:0] pd_mem [FRAME_SAMPLES];
	logic [15:0] hist_rd_q;
	logic [15:0] pp_rd_q;
	logic [15:0] pd_rd_q;

	logic            valid_s1;
	res_t            res_s1;
	word_src_t       src_s1;
	logic [PD_W-1:0] pidx_s1;

	logic hs_issue, buf_rst, cnt_rst, imp_toggle, hist_we, push_we;
	logic send_start, send_issue, send_done;

	logic [8:0]      hp9, past9;
	logic [7:0]      past8;
	logic [HI_W-1:0] hp_idx, past_idx;
	logic [WI_W-1:0] sidx;
	logic [PP_W-1:0] pp_raddr;
	logic [PD_W-1:0] pd_raddr;
	logic [15:0]     push_val;
	logic [WP_W-1:0] wp_next;
	logic [2:0]      dph_next;
	logic [11:0]     tick_sum;
	logic            pd_we;

	// history addressing, modulo depth by one compare and subtract
	assign past8    = hp_q - {5'd0, dph_q} - phase_delay(dph_q);
	assign hp9      = {1'b0, hp_q};
	assign past9    = {1'b0, past8};
	assign hp_idx   = HI_W'((hp9 >= HD9) ? (hp9 - HD9) : hp9);
	assign past_idx = HI_W'((past9 >= HD9) ? (past9 - HD9) : past9);

	assign sidx     = widx_q - WI_W'(2);
	assign pp_raddr = base_q + PP_W'(sidx);
	assign pd_raddr = PD_W'(sidx);
	assign push_val = !use_hist_q ? sample_q : (hv_q ? hist_rd_q : 16'd0);
	assign wp_next  = wp_q + WP_W'(1);
	assign dph_next = (dph_q == PHASE_LAST) ? 3'd0 : dph_q + 3'd1;
	assign tick_sum = {1'b0, tick_q} + (imp_q ? TICK_STEP_IMP : TICK_STEP_SIG);
	assign pd_we    = valid_s1 && (src_s1 == SRC_STORE);

	// control outputs
	always_comb begin
		op_pop     = 1'b0;
		hs_issue   = 1'b0;
		buf_rst    = 1'b0;
		cnt_rst    = 1'b0;
		imp_toggle = 1'b0;
		hist_we    = 1'b0;
		push_we    = 1'b0;
		send_start = 1'b0;
		send_issue = 1'b0;
		send_done  = 1'b0;
		lp_d       = lp_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!op_empty) begin
					case (op.kind)
						K_SAMPLE: begin
							op_pop  = 1'b1;
							hist_we = imp_q;
						end
						K_TOGGLE: begin
							op_pop     = 1'b1;
							imp_toggle = 1'b1;
							if (lp_q != LP_WAIT) begin
								lp_d    = LP_WAIT;
								buf_rst = 1'b1;
								cnt_rst = 1'b1;
							end
						end
						K_HANDSHAKE: begin
							if (out_room) begin
								op_pop   = 1'b1;
								hs_issue = 1'b1;
								buf_rst  = (lp_q == LP_START) || (lp_q == LP_STREAM);
								lp_d     = (op.accepted || lp_q == LP_RESP) ? LP_RESP : LP_WAIT;
							end
						end
						K_START: begin
							op_pop = 1'b1;
							if (lp_q == LP_RESP) begin
								buf_rst = 1'b1;
								cnt_rst = 1'b1;
								lp_d    = LP_START;
							end
						end
						K_SEND: begin
							op_pop     = 1'b1;
							send_start = pend_q || (ready_q != RH_NONE);
						end
						default: op_pop = 1'b1;
					endcase
				end
			end
			ST_PUSH: begin
				push_we = 1'b1;
			end
			ST_SEND: begin
				send_issue = out_room;
				send_done  = out_room && (widx_q == WI_LAST);
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!op_empty && op.kind == K_SAMPLE) begin
					state_d = ST_PUSH;
				end else if (send_start) begin
					state_d = ST_SEND;
				end
			end
			ST_PUSH: state_d = ST_IDLE;
			ST_SEND: begin
				if (send_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			lp_q     <= LP_WAIT;
			imp_q    <= 1'b0;
			wp_q     <= '0;
			dph_q    <= '0;
			ready_q  <= RH_NONE;
			hp_q     <= '0;
			hvalid_q <= '0;
			pend_q   <= 1'b0;
			seq_q    <= '0;
			type_q   <= '0;
			tick_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			lp_q     <= lp_d;
			imp_q    <= imp_q ^ imp_toggle;
			valid_s1 <= hs_issue || send_issue;
			if (buf_rst) begin
				wp_q     <= '0;
				dph_q    <= '0;
				ready_q  <= RH_NONE;
				hp_q     <= '0;
				hvalid_q <= '0;
				pend_q   <= 1'b0;
			end else if (hist_we) begin
				hp_q             <= hp_q + 8'd1;
				hvalid_q[hp_idx] <= 1'b1;
			end else if (push_we) begin
				if (wp_next == WP_FULL) begin
					ready_q <= RH_SECOND;
					wp_q    <= '0;
					dph_q   <= '0;
				end else begin
					if (wp_next == WP_HALF) begin
						ready_q <= RH_FIRST;
					end
					wp_q  <= wp_next;
					dph_q <= dph_next;
				end
			end else if (send_start && !pend_q) begin
				ready_q <= RH_NONE;
				pend_q  <= 1'b1;
			end else if (send_done && acc_q) begin
				pend_q <= 1'b0;
			end
			if (cnt_rst) begin
				seq_q  <= '0;
				type_q <= '0;
				tick_q <= '0;
			end else if (send_done && acc_q) begin
				seq_q <= seq_q + 8'd1;
				if (seq_q == 8'hFF) begin
					type_q <= type_q + 4'd1;
				end
				tick_q <= (tick_sum > TICK_LIMIT) ? 11'd0 : tick_sum[10:0];
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (!op_empty && state_q == ST_IDLE && op.kind == K_SAMPLE) begin
			sample_q   <= op.sample;
			use_hist_q <= imp_q && (past_idx != hp_idx);
		end
		if (send_start) begin
			widx_q     <= '0;
			acc_q      <= op.accepted;
			src_pend_q <= pend_q;
			if (!pend_q) begin
				base_q <= (ready_q == RH_SECOND) ? PP_BASE2 : '0;
			end
		end else if (send_issue) begin
			widx_q <= widx_q + WI_W'(1);
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hp_idx] <= op.sample;
		end
		hist_rd_q <= hist_mem[past_idx];
		hv_q      <= hvalid_q[past_idx];
	end

	always_ff @(posedge clk) begin
		if (push_we) begin
			pp_mem[wp_q[PP_W-1:0]] <= push_val;
		end
		pp_rd_q <= pp_mem[pp_raddr];
	end

	always_ff @(posedge clk) begin
		if (pd_we) begin
			pd_mem[pidx_s1] <= pp_rd_q;
		end
		pd_rd_q <= pd_mem[pd_raddr];
	end

	// issue stage into s1
	always_ff @(posedge clk) begin
		if (hs_issue) begin
			res_s1.result_kind      <= KIND_HANDSHAKE;
			res_s1.frame_word       <= 16'd0;
			res_s1.is_last          <= 1'b1;
			res_s1.response_variant <= imp_q;
			src_s1                  <= SRC_CONST;
		end else if (send_issue) begin
			res_s1.result_kind      <= KIND_DATA;
			res_s1.is_last          <= (widx_q == WI_LAST);
			res_s1.response_variant <= 1'b0;
			pidx_s1                 <= pd_raddr;
			if (widx_q == WI_HEAD) begin
				res_s1.frame_word <= {TYPE_BASE, type_q, seq_q};
				src_s1            <= SRC_CONST;
			end else if (widx_q == WI_TICK) begin
				res_s1.frame_word <= {5'd0, tick_q};
				src_s1            <= SRC_CONST;
			end else begin
				res_s1.frame_word <= 16'd0;
				src_s1            <= src_pend_q ? SRC_PENDING : SRC_STORE;
			end
		end
	end

	always_comb begin
		res      = res_s1;
		res_push = valid_s1;
		case (src_s1)
			SRC_STORE:   res.frame_word = pp_rd_q;
			SRC_PENDING: res.frame_word = pd_rd_q;
			default:     res.frame_word = res_s1.frame_word;
		endcase
	end

endmodule

### rtl/sample_framer_with_handshake.sv
// ----------------------------------------------------------------------------
// sample_framer_with_handshake
// Converter sample framer with host link handshake.
// ----------------------------------------------------------------------------
// Request channel: a FIFO-style write port (push, full). Each request carries
// an opcode with its fields: a sample, a host command byte or a frame send.
// Result channel: a FIFO-style read port (empty, pop). A result is valid while
// empty is low and is consumed on pop.
// Requests pass a classifier into a 2-deep queue; an engine works them off one
// at a time. A sample passes a history read, then a store write. A frame send
// emits 32 words, one per cycle while the 4-deep result queue has room; each
// word is registered in the issue stage before it enters the result queue. The
// rate is set by the engine issuing one word per cycle from two memory ports.
// When pop stalls, the result queue fills, the engine holds, the request queue
// fills and full rises; nothing is lost.
// Reset (arst_n low) empties both queues, clears mode, link phase, counters,
// and history valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sample_framer_with_handshake #(
	parameter int FRAME_SAMPLES = 30,
	parameter int HISTORY_DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [15:0] sample_value,
	input  logic [7:0]  command_byte,
	input  logic        link_configured,
	input  logic        host_accepts,
	output logic        empty,
	input  logic        pop,
	output logic        result_kind,
	output logic [15:0] frame_word,
	output logic        is_last,
	output logic        response_variant
);
	import sfh_pkg::*;

	localparam int OP_DEPTH  = 2;
	localparam int OUT_DEPTH = 4;
	localparam int OP_CW     = $clog2(OP_DEPTH + 1);
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	logic              keep;
	op_t               op_in;
	op_t               op_head;
	logic              op_empty;
	logic              op_pop;
	logic [OP_CW-1:0]  op_count;
	logic              res_push;
	res_t              res_in;
	res_t              res_head;
	logic              res_full;
	logic [OUT_CW-1:0] res_count;
	logic              out_room;

	assign out_room = (res_count <= OUT_CW'(OUT_DEPTH - 2));

	sfh_front u_front (
		.opcode          (opcode),
		.sample_value    (sample_value),
		.command_byte    (command_byte),
		.link_configured (link_configured),
		.host_accepts    (host_accepts),
		.keep            (keep),
		.op              (op_in)
	);

	sfh_fifo #(
		.WIDTH ($bits(op_t)),
		.DEPTH (OP_DEPTH)
	) u_op_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && keep),
		.wr_data (op_in),
		.rd_en   (op_pop),
		.rd_data (op_head),
		.full    (full),
		.empty   (op_empty),
		.count   (op_count)
	);

	sfh_back #(
		.FRAME_SAMPLES (FRAME_SAMPLES),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_empty (op_empty),
		.op       (op_head),
		.op_pop   (op_pop),
		.out_room (out_room),
		.res_push (res_push),
		.res      (res_in)
	);

	sfh_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.rd_en   (pop),
		.rd_data (res_head),
		.full    (res_full),
		.empty   (empty),
		.count   (res_count)
	);

	assign result_kind      = res_head.result_kind;
	assign frame_word       = res_head.frame_word;
	assign is_last          = res_head.is_last;
	assign response_variant = res_head.response_variant;

	// result queue never overflows: the engine issues only with two free slots
	logic unused_ok;
	assign unused_ok = res_full & (op_count == '0);

endmodule

### rtl/sfh_checker.sv
// ----------------------------------------------------------------------------
// sfh_checker
// Port-level checks on the result channel of the sample framer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        result_kind,
	input logic [15:0] frame_word,
	input logic        is_last,
	input logic        response_variant
);

	`SFH_ASSERT_NXT(a_stall_hold, clk, arst_n, !empty && !pop, !empty && $stable(frame_word) && $stable(result_kind) && $stable(is_last))
	`SFH_ASSERT_IMP(a_hs_last, clk, arst_n, !empty && result_kind, is_last)
	`SFH_ASSERT_IMP(a_hs_zero, clk, arst_n, !empty && result_kind, frame_word == 16'd0)
	`SFH_ASSERT_IMP(a_data_var, clk, arst_n, !empty && !result_kind, !response_variant)

endmodule

bind sample_framer_with_handshake sfh_checker u_sfh_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.empty            (empty),
	.pop              (pop),
	.result_kind      (result_kind),
	.frame_word       (frame_word),
	.is_last          (is_last),
	.response_variant (response_variant)
);

### dv/tb_sample_framer_with_handshake.sv
// ----------------------------------------------------------------------------
// tb_sample_framer_with_handshake
// Self-checking bench for the sample framer with host link handshake.
// ----------------------------------------------------------------------------
// Requests go in through the push/full port. Each accepted request also goes
// to a scoreboard that tracks mode, link phase, the ping-pong halves, the
// sample history and the frame counters. From these it builds the words the
// block must return, and checks each popped word against the oldest one.
// A short directed pass covers the handshake, mode toggle, start, ignored
// commands and send attempts that must stay silent. Random sample bursts, sends,
// link bring-ups and requests run in four phases of sender idling and pop stalls.
// ----------------------------------------------------------------------------
module tb_sample_framer_with_handshake;
	import sfh_pkg::*;

	localparam int FRAME_LEN = 30;
	localparam int HIST_LEN  = 128;
	localparam int HALF_SPAN = 2 * FRAME_LEN;
	localparam logic [1:0] OPC_UNUSED = 2'd3;
	localparam logic [7:0] DELAY_TAB [6] = '{8'd0, 8'd13, 8'd25, 8'd38, 8'd50, 8'd63};

	class framer_scoreboard;
		logic          imp_mode;
		link_phase_t   phase;
		logic [5:0]    wr_pos;
		ready_half_t   ready;
		logic [7:0]    hist_ptr;
		logic [15:0]   history [HIST_LEN];
		logic [15:0]   halves [HALF_SPAN];
		logic [15:0]   held_frame [FRAME_LEN];
		logic          frame_held;
		logic [7:0]    seq;
		logic [3:0]    type_nib;
		logic [10:0]   tick;
		res_t          awaited_words[$];
		int            errors;

		function new();
			imp_mode = 1'b0;
			phase = LP_WAIT;
			errors = 0;
			foreach (halves[i]) halves[i] = '0;
			foreach (held_frame[i]) held_frame[i] = '0;
			clear_buffers();
			clear_counters();
		endfunction

		function void clear_buffers();
			wr_pos = '0;
			ready = RH_NONE;
			frame_held = 1'b0;
			hist_ptr = '0;
			foreach (history[i]) history[i] = '0;
		endfunction

		function void clear_counters();
			seq = '0;
			type_nib = '0;
			tick = '0;
		endfunction

		function void add_word(logic kind, logic [15:0] word, logic last, logic variant);
			res_t r;
			r.result_kind = kind;
			r.frame_word = word;
			r.is_last = last;
			r.response_variant = variant;
			awaited_words.push_back(r);
		endfunction

		function void store_sample(logic [15:0] smp);
			int ph;
			logic [7:0] past;
			if (imp_mode) begin
				ph = wr_pos % 6;
				history[hist_ptr % HIST_LEN] = smp;
				past = hist_ptr - 8'(ph) - DELAY_TAB[ph];
				smp = history[past % HIST_LEN];
				hist_ptr = hist_ptr + 8'd1;
			end
			if (wr_pos >= HALF_SPAN)
				wr_pos = '0;
			halves[wr_pos] = smp;
			wr_pos = wr_pos + 6'd1;
			if (wr_pos == FRAME_LEN) begin
				ready = RH_FIRST;
			end else if (wr_pos >= HALF_SPAN) begin
				ready = RH_SECOND;
				wr_pos = '0;
			end
		endfunction

		function void host_command(logic [7:0] cmd, logic acc);
			if (cmd == CMD_TOGGLE) begin
				imp_mode = ~imp_mode;
				if (phase != LP_WAIT) begin
					phase = LP_WAIT;
					clear_buffers();
					clear_counters();
				end
				return;
			end
			case (phase)
				LP_WAIT: begin
					if (cmd == CMD_HANDSHAKE) begin
						add_word(KIND_HANDSHAKE, 16'h0, 1'b1, imp_mode);
						if (acc)
							phase = LP_RESP;
					end
				end
				LP_RESP: begin
					if (cmd == CMD_HANDSHAKE) begin
						add_word(KIND_HANDSHAKE, 16'h0, 1'b1, imp_mode);
					end else if (cmd == CMD_START) begin
						clear_buffers();
						clear_counters();
						phase = LP_START;
					end
				end
				default: begin
					if (cmd == CMD_HANDSHAKE) begin
						phase = LP_WAIT;
						clear_buffers();
						add_word(KIND_HANDSHAKE, 16'h0, 1'b1, imp_mode);
						if (acc)
							phase = LP_RESP;
					end
				end
			endcase
		endfunction

		function void send_frame(logic acc);
			int base;
			logic [11:0] tick_after;
			if (!frame_held) begin
				if (ready == RH_FIRST)
					base = 0;
				else if (ready == RH_SECOND)
					base = FRAME_LEN;
				else
					return;
				for (int i = 0; i < FRAME_LEN; i++)
					held_frame[i] = halves[base + i];
				ready = RH_NONE;
				frame_held = 1'b1;
			end
			add_word(KIND_DATA, {TYPE_BASE, type_nib, seq}, 1'b0, 1'b0);
			add_word(KIND_DATA, {5'd0, tick}, 1'b0, 1'b0);
			for (int i = 0; i < FRAME_LEN; i++)
				add_word(KIND_DATA, held_frame[i], i == FRAME_LEN - 1, 1'b0);
			if (acc) begin
				frame_held = 1'b0;
				seq = seq + 8'd1;
				if (seq == 8'd0)
					type_nib = type_nib + 4'd1;
				tick_after = {1'b0, tick} + (imp_mode ? TICK_STEP_IMP : TICK_STEP_SIG);
				tick = (tick_after > TICK_LIMIT) ? 11'd0 : tick_after[10:0];
			end
		endfunction

		function void apply_request(logic [1:0] op, logic [15:0] smp, logic [7:0] cmd,
				logic linked, logic acc);
			case (op)
				OPC_SAMPLE:  store_sample(smp);
				OPC_COMMAND: host_command(cmd, acc);
				OPC_SEND:    if (linked) send_frame(acc);
				default:     ;
			endcase
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (awaited_words.size() == 0) begin
				$error("unexpected result: kind %0d word %h last %0d variant %0d",
					got.result_kind, got.frame_word, got.is_last, got.response_variant);
				errors++;
				return;
			end
			want = awaited_words.pop_front();
			if (got.result_kind !== want.result_kind) begin
				$error("result_kind expected %0d actual %0d", want.result_kind, got.result_kind);
				errors++;
			end
			if (got.frame_word !== want.frame_word) begin
				$error("frame_word expected %h actual %h", want.frame_word, got.frame_word);
				errors++;
			end
			if (got.is_last !== want.is_last) begin
				$error("is_last expected %0d actual %0d", want.is_last, got.is_last);
				errors++;
			end
			if (got.response_variant !== want.response_variant) begin
				$error("response_variant expected %0d actual %0d",
					want.response_variant, got.response_variant);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  opcode = OPC_SAMPLE;
	logic [15:0] sample_value = '0;
	logic [7:0]  command_byte = '0;
	logic        link_configured = 1'b0;
	logic        host_accepts = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic        result_kind;
	logic [15:0] frame_word;
	logic        is_last;
	logic        response_variant;

	framer_scoreboard sb;
	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	int requests_sent = 0;

	sample_framer_with_handshake dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.opcode           (opcode),
		.sample_value     (sample_value),
		.command_byte     (command_byte),
		.link_configured  (link_configured),
		.host_accepts     (host_accepts),
		.empty            (empty),
		.pop              (pop),
		.result_kind      (result_kind),
		.frame_word       (frame_word),
		.is_last          (is_last),
		.response_variant (response_variant)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_t got;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				got.result_kind = result_kind;
				got.frame_word = frame_word;
				got.is_last = is_last;
				got.response_variant = response_variant;
				sb.check_result(got);
			end
			pop <= ($urandom_range(99) >= pop_stall_pct);
		end
	end

	task automatic issue(input logic [1:0] op, input logic [15:0] smp, input logic [7:0] cmd,
			input logic linked, input logic acc);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		sample_value <= smp;
		command_byte <= cmd;
		link_configured <= linked;
		host_accepts <= acc;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.apply_request(op, smp, cmd, linked, acc);
		if (op != OPC_UNUSED)
			requests_sent++;
	endtask

	function automatic logic [7:0] pick_command();
		case ($urandom_range(4))
			0: return CMD_TOGGLE;
			1: return CMD_HANDSHAKE;
			2: return CMD_START;
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		int target;
		int pick;
		int n;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: silent items, handshake paths, toggle, start
		issue(OPC_UNUSED, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
		issue(OPC_COMMAND, 16'h0000, 8'h00, 1'b0, 1'b0);
		issue(OPC_COMMAND, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
		issue(OPC_SEND, 16'hFFFF, 8'hFF, 1'b0, 1'b1);
		issue(OPC_SEND, 16'h0000, 8'h00, 1'b1, 1'b1);
		issue(OPC_COMMAND, 16'h0000, CMD_START, 1'b1, 1'b1);
		issue(OPC_COMMAND, 16'h0000, CMD_HANDSHAKE, 1'b1, 1'b0);
		issue(OPC_COMMAND, 16'h0000, CMD_HANDSHAKE, 1'b1, 1'b1);
		issue(OPC_COMMAND, 16'h0000, CMD_HANDSHAKE, 1'b0, 1'b0);
		issue(OPC_COMMAND, 16'h0000, CMD_TOGGLE, 1'b1, 1'b1);
		issue(OPC_COMMAND, 16'h0000, CMD_HANDSHAKE, 1'b1, 1'b1);
		issue(OPC_COMMAND, 16'h0000, CMD_START, 1'b1, 1'b1);
		issue(OPC_SAMPLE, 16'hFFFF, 8'h00, 1'b0, 1'b0);
		issue(OPC_SAMPLE, 16'h0000, 8'hFF, 1'b1, 1'b1);
		issue(OPC_SAMPLE, 16'h8000, 8'h00, 1'b0, 1'b1);
		issue(OPC_SAMPLE, 16'h0001, 8'h00, 1'b1, 1'b0);
		issue(OPC_COMMAND, 16'h0000, CMD_HANDSHAKE, 1'b1, 1'b0);
		issue(OPC_COMMAND, 16'h0000, CMD_TOGGLE, 1'b0, 1'b0);
		issue(OPC_COMMAND, 16'h0000, CMD_START, 1'b0, 1'b0);
		issue(OPC_SAMPLE, 16'h7FFF, 8'h00, 1'b0, 1'b0);
		issue(OPC_SEND, 16'h0000, 8'h00, 1'b1, 1'b0);

		target = requests_sent;
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
				1: begin send_idle_pct = 83; pop_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  pop_stall_pct = 83; end
				default: begin send_idle_pct = 25; pop_stall_pct = 25; end
			endcase
			target += 120;
			while (requests_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 65) begin
					// sample burst, then a few send attempts
					n = ($urandom_range(3) == 0) ? FRAME_LEN : $urandom_range(1, 70);
					repeat (n)
						issue(OPC_SAMPLE, 16'($urandom), 8'($urandom), 1'($urandom),
							1'($urandom));
					repeat ($urandom_range(1, 3))
						issue(OPC_SEND, 16'($urandom), 8'($urandom),
							$urandom_range(9) != 0, $urandom_range(9) < 7);
				end else if (pick < 82) begin
					// link bring-up, sometimes with a mode flip
					if ($urandom_range(1) == 0)
						issue(OPC_COMMAND, 16'($urandom), CMD_TOGGLE, 1'($urandom),
							1'($urandom));
					issue(OPC_COMMAND, 16'($urandom), CMD_HANDSHAKE, 1'($urandom),
						$urandom_range(3) != 0);
					if ($urandom_range(3) != 0)
						issue(OPC_COMMAND, 16'($urandom), CMD_START, 1'($urandom),
							1'($urandom));
				end else begin
					issue(2'($urandom), 16'($urandom), pick_command(), 1'($urandom),
						1'($urandom));
				end
			end
		end

		push <= 1'b0;
		pop_stall_pct = 0;
		while (sb.awaited_words.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
